/* src/dplru_pkg.sv */
// dplru_pkg: shared types and constants for the demand paging LRU frame manager.
// Used by dplru_ctrl, dplru_dp, the top level and the checker; no dependencies.
`default_nettype none

package dplru_pkg;

  // Fixed field widths
  localparam int CFG_W  = 7;
  localparam int FILE_W = 2;

  // Pool size after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Result kind
  typedef enum logic {
    KIND_FILL    = 1'b0,
    KIND_UPGRADE = 1'b1
  } kind_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic start;      // transfer taken: latch request, clear scan results
    logic rd;         // read frame tables at rd_idx
    logic scan_eval;  // evaluate read data of frame ev_idx for lookup
    logic decide;     // pick frame, update flags and tag table
    logic upd_eval;   // rewrite recency rank of frame ev_idx
    logic load;       // load result register
  } cmd_t;

endpackage

`default_nettype wire

/* src/dplru_ctrl.sv */
// dplru_ctrl: sequencer for the frame manager; walks the frame tables twice
// per fault (lookup scan, rank update) and owns both handshakes. Uses dplru_pkg.
`default_nettype none

module dplru_ctrl #(
  parameter int FRAMES = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire                        out_ready,
  output dplru_pkg::cmd_t            cmd,
  output logic [$clog2(FRAMES)-1:0]  rd_idx,
  output logic [$clog2(FRAMES)-1:0]  ev_idx
);

  localparam int FW = $clog2(FRAMES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWAIT,
    S_DECIDE,
    S_UPD,
    S_UWAIT,
    S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [FW-1:0] ev_idx_r, ev_idx_nxt;
  logic          stg_scan_r, stg_scan_nxt;
  logic          stg_upd_r, stg_upd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          last;

  assign last = (idx_r == FW'(FRAMES - 1));

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ev_idx_nxt    = idx_r;
    stg_scan_nxt  = (state_r == S_SCAN);
    stg_upd_nxt   = (state_r == S_UPD);
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd  = 1'b1;
        idx_nxt = last ? '0 : idx_r + 1'b1;
        if (last) begin
          state_nxt = S_SWAIT;
        end
      end
      S_SWAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.rd  = 1'b1;
        idx_nxt = last ? '0 : idx_r + 1'b1;
        if (last) begin
          state_nxt = S_UWAIT;
        end
      end
      S_UWAIT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // wait for the result register to be free
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // read data arrives in the cycle after the read
    cmd.scan_eval = stg_scan_r;
    cmd.upd_eval  = stg_upd_r;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      ev_idx_r    <= '0;
      stg_scan_r  <= 1'b0;
      stg_upd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ev_idx_r    <= ev_idx_nxt;
      stg_scan_r  <= stg_scan_nxt;
      stg_upd_r   <= stg_upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign rd_idx    = idx_r;
  assign ev_idx    = ev_idx_r;

endmodule

`default_nettype wire

/* src/dplru_dp.sv */
// dplru_dp: frame tables (valid/dirty flags, tag and rank memories), lookup
// scan registers, rank update and result register. Uses dplru_pkg.
`default_nettype none

module dplru_dp #(
  parameter int FRAMES    = 64,
  parameter int FILES     = 4,
  parameter int PAGE_BITS = 20
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  dplru_pkg::cmd_t                  cmd,
  input  wire  [$clog2(FRAMES)-1:0]        rd_idx,
  input  wire  [$clog2(FRAMES)-1:0]        ev_idx,
  input  wire                              cfg_we,
  input  wire  [dplru_pkg::CFG_W-1:0]      cfg_data,
  input  wire  [dplru_pkg::FILE_W-1:0]     in_file_id,
  input  wire  [PAGE_BITS-1:0]             in_page_index,
  output logic                             out_access_kind,
  output logic [$clog2(FRAMES)-1:0]        out_frame,
  output logic                             out_evicted,
  output logic [dplru_pkg::FILE_W-1:0]     out_evicted_file,
  output logic [PAGE_BITS-1:0]             out_evicted_page,
  output logic                             out_write_back
);

  localparam int FW  = $clog2(FRAMES);
  localparam int CW  = $clog2(FRAMES + 1);
  localparam int TW  = dplru_pkg::FILE_W + PAGE_BITS;
  localparam int NW  = (dplru_pkg::CFG_W > FW + 1) ? dplru_pkg::CFG_W : FW + 1;

  // Pool size register
  logic [dplru_pkg::CFG_W-1:0] cfg_r;
  logic [NW-1:0]               pool_n;

  // Frame flags and tables
  logic [FRAMES-1:0] valid_r;
  logic [FRAMES-1:0] dirty_r;
  logic [TW-1:0]     tag_mem  [FRAMES];
  logic [FW-1:0]     rank_mem [FRAMES];
  logic [TW-1:0]     tag_q_r;
  logic [FW-1:0]     rank_q_r;

  // Request
  logic [dplru_pkg::FILE_W-1:0] fid_m;
  logic [TW-1:0]                req_tag_r;

  // Scan results
  logic [CW-1:0] cnt_r;
  logic          hit_r;
  logic [FW-1:0] hit_idx_r;
  logic [FW-1:0] hit_rank_r;
  logic          free_r;
  logic [FW-1:0] free_idx_r;
  logic          vic_r;
  logic [FW-1:0] vic_idx_r;
  logic [FW-1:0] vic_rank_r;
  logic [TW-1:0] vic_tag_r;
  logic          vic_dirty_r;

  // Decision
  logic [FW-1:0]    f_nxt, f_r;
  logic [CW-1:0]    old_nxt, old_r;
  logic             evict_nxt, evict_r;
  dplru_pkg::kind_t kind_nxt, kind_r;

  // Per-frame evaluation
  logic          ev_valid;
  logic          ev_in_pool;
  logic          tag_hit;
  logic [FW-1:0] rank_dec;
  logic [FW-1:0] rank_new;
  logic          rank_we;
  logic [FW-1:0] rank_wd;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= dplru_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  // Clamp pool size to 1 .. FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      pool_n = NW'(1);
    end else if (NW'(cfg_r) > NW'(FRAMES)) begin
      pool_n = NW'(FRAMES);
    end else begin
      pool_n = NW'(cfg_r);
    end
  end

  // File number folded into 0 .. FILES-1 (input is at most 3)
  always_comb begin
    fid_m = in_file_id;
    for (int k = 0; k < 3; k++) begin
      if (int'(fid_m) >= FILES) begin
        fid_m = fid_m - dplru_pkg::FILE_W'(FILES);
      end
    end
  end

  // Lookup of the frame under evaluation
  assign ev_valid   = valid_r[ev_idx];
  assign ev_in_pool = (NW'(ev_idx) < pool_n);
  assign tag_hit    = (tag_q_r == req_tag_r);

  // Scan: hit, first free frame in pool, LRU victim in pool, resident count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      vic_r  <= 1'b0;
    end else if (cmd.start) begin
      cnt_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      vic_r  <= 1'b0;
    end else if (cmd.scan_eval) begin
      if (ev_valid) begin
        cnt_r <= cnt_r + 1'b1;
        if (!hit_r && tag_hit) begin
          hit_r <= 1'b1;
        end
      end
      if (ev_in_pool && !ev_valid && !free_r) begin
        free_r <= 1'b1;
      end
      if (ev_in_pool && ev_valid && (!vic_r || rank_q_r > vic_rank_r)) begin
        vic_r <= 1'b1;
      end
    end
  end

  // Scan payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_tag_r <= {fid_m, in_page_index};
    end
    if (cmd.scan_eval) begin
      if (ev_valid && !hit_r && tag_hit) begin
        hit_idx_r  <= ev_idx;
        hit_rank_r <= rank_q_r;
      end
      if (ev_in_pool && !ev_valid && !free_r) begin
        free_idx_r <= ev_idx;
      end
      if (ev_in_pool && ev_valid && (!vic_r || rank_q_r > vic_rank_r)) begin
        vic_idx_r   <= ev_idx;
        vic_rank_r  <= rank_q_r;
        vic_tag_r   <= tag_q_r;
        vic_dirty_r <= dirty_r[ev_idx];
      end
    end
  end

  // Frame choice and rank bound for the update pass
  always_comb begin
    if (hit_r) begin
      f_nxt     = hit_idx_r;
      old_nxt   = CW'(hit_rank_r);
      evict_nxt = 1'b0;
      kind_nxt  = dplru_pkg::KIND_UPGRADE;
    end else if (free_r) begin
      f_nxt     = free_idx_r;
      old_nxt   = cnt_r;
      evict_nxt = 1'b0;
      kind_nxt  = dplru_pkg::KIND_FILL;
    end else begin
      f_nxt     = vic_idx_r;
      old_nxt   = cnt_r - 1'b1;
      evict_nxt = 1'b1;
      kind_nxt  = dplru_pkg::KIND_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      f_r     <= f_nxt;
      old_r   <= old_nxt;
      evict_r <= evict_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Frame flags: hit marks dirty, fill makes valid and clean
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else if (cmd.decide) begin
      if (hit_r) begin
        dirty_r[f_nxt] <= 1'b1;
      end else begin
        valid_r[f_nxt] <= 1'b1;
        dirty_r[f_nxt] <= 1'b0;
      end
    end
  end

  // Tag table
  always_ff @(posedge clk) begin
    if (cmd.decide && !hit_r) begin
      tag_mem[f_nxt] <= req_tag_r;
    end
    if (cmd.rd) begin
      tag_q_r <= tag_mem[rd_idx];
    end
  end

  // Rank update: close the victim's gap, then age frames newer than the bound
  always_comb begin
    rank_dec = (evict_r && rank_q_r > vic_rank_r) ? rank_q_r - 1'b1 : rank_q_r;
    rank_new = (CW'(rank_dec) < old_r) ? rank_dec + 1'b1 : rank_dec;
    rank_we  = cmd.upd_eval && ((ev_idx == f_r) || ev_valid);
    rank_wd  = (ev_idx == f_r) ? '0 : rank_new;
  end

  // Rank table
  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[ev_idx] <= rank_wd;
    end
    if (cmd.rd) begin
      rank_q_r <= rank_mem[rd_idx];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_access_kind  <= kind_r;
      out_frame        <= f_r;
      out_evicted      <= evict_r;
      out_evicted_file <= evict_r ? vic_tag_r[TW-1:PAGE_BITS] : '0;
      out_evicted_page <= evict_r ? vic_tag_r[PAGE_BITS-1:0] : '0;
      out_write_back   <= evict_r & vic_dirty_r;
    end
  end

endmodule

`default_nettype wire

/* src/demand_paging_lru_frame_manager.sv */
// Demand paging frame manager with LRU replacement, top level.
// Instantiates dplru_ctrl (sequencer) and dplru_dp (tables and datapath).
//
// Usage:
//   Input channel in_valid/in_ready carries one page fault (file, page).
//   Output channel out_valid/out_ready carries one result per fault: fill
//   or upgrade, the frame used, and any eviction with its write-back flag.
//   cfg_we/cfg_data set the pool size (frames 0 .. n-1); write only while
//   idle. Values of 0 act as 1, values above FRAMES act as FRAMES.
// Processing:
//   Each fault runs from transfer to result valid through a lookup pass over
//   the tag/rank memories, a wait state for the last read data, a decision
//   state, a read-modify-write pass over the rank memory, another wait state
//   for the last read data, and a state that loads the result register. One
//   fault is worked on at a time; in_ready is high whenever the sequencer is
//   idle, also while a result waits in the output register. The next fault
//   can be taken in the same cycle as the result turns valid.
// Reset and stall:
//   Reset clears all frame valid and dirty flags and the pool size returns
//   to 64; no clearing pass is needed. If the receiver stalls, the result is
//   held and the next fault is processed but held back before its result
//   load until the output register is free.
`default_nettype none

module demand_paging_lru_frame_manager #(
  parameter int FRAMES    = 64,
  parameter int FILES     = 4,
  parameter int PAGE_BITS = 20
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [dplru_pkg::CFG_W-1:0]      cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [dplru_pkg::FILE_W-1:0]     in_file_id,
  input  wire  [PAGE_BITS-1:0]             in_page_index,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_access_kind,
  output logic [$clog2(FRAMES)-1:0]        out_frame,
  output logic                             out_evicted,
  output logic [dplru_pkg::FILE_W-1:0]     out_evicted_file,
  output logic [PAGE_BITS-1:0]             out_evicted_page,
  output logic                             out_write_back
);

  localparam int FW = $clog2(FRAMES);

  dplru_pkg::cmd_t cmd;
  logic [FW-1:0]   rd_idx;
  logic [FW-1:0]   ev_idx;

  // Sequencer
  dplru_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .ev_idx    (ev_idx)
  );

  // Frame tables and datapath
  dplru_dp #(
    .FRAMES    (FRAMES),
    .FILES     (FILES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_idx           (rd_idx),
    .ev_idx           (ev_idx),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_file_id       (in_file_id),
    .in_page_index    (in_page_index),
    .out_access_kind  (out_access_kind),
    .out_frame        (out_frame),
    .out_evicted      (out_evicted),
    .out_evicted_file (out_evicted_file),
    .out_evicted_page (out_evicted_page),
    .out_write_back   (out_write_back)
  );

endmodule

`default_nettype wire

/* src/dplru_checker.sv */
// dplru_checker: port-level assertions for the frame manager, bound to the
// top level below. Uses dplru_pkg for field widths.
`default_nettype none

module dplru_checker #(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 20
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          out_access_kind,
  input wire [$clog2(FRAMES)-1:0]     out_frame,
  input wire                          out_evicted,
  input wire [dplru_pkg::FILE_W-1:0]  out_evicted_file,
  input wire [PAGE_BITS-1:0]          out_evicted_page,
  input wire                          out_write_back
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame)
      && $stable(out_evicted) && $stable(out_evicted_page))
    else $error("result changed while stalled");

  // Eviction fields are zero without an eviction
  a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> !out_write_back && out_evicted_file == '0
      && out_evicted_page == '0)
    else $error("eviction fields set without eviction");

  // An upgrade never evicts
  a_upgrade_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access_kind |-> !out_evicted)
    else $error("upgrade reported an eviction");

  // One fault at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second fault taken while busy");

  // Reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind demand_paging_lru_frame_manager dplru_checker #(
  .FRAMES    (FRAMES),
  .PAGE_BITS (PAGE_BITS)
) u_dplru_checker (.*);

`default_nettype wire

/* dv/tb_demand_paging_lru_frame_manager.sv */
// Self-checking testbench for demand_paging_lru_frame_manager: page faults are
// driven on a valid/ready channel and each result is checked against a frame
// table predictor kept here. Depends on dplru_pkg and the RTL top level only.
module tb_demand_paging_lru_frame_manager;

  localparam int NFRAMES         = 64;
  localparam int PAGE_W          = 20;
  localparam int FRAME_W         = $clog2(NFRAMES);
  localparam int FILE_W          = dplru_pkg::FILE_W;
  localparam int CFG_W           = dplru_pkg::CFG_W;
  localparam int FAULT_CYCLES    = 2 * NFRAMES + 4;
  localparam int LONG_HOLD       = 800;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 40;
  localparam int RANDOM_PHASES   = 12;
  localparam int FAULTS_PER_PHASE = 78;

  // Receiver stall patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_SPARSE = 2;

  typedef struct packed {
    logic [FILE_W-1:0] file_id;
    logic [PAGE_W-1:0] page;
  } fault_t;

  typedef struct packed {
    dplru_pkg::kind_t   kind;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [FILE_W-1:0]  ev_file;
    logic [PAGE_W-1:0]  ev_page;
    logic               write_back;
  } frame_result_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_we        = 1'b0;
  logic [CFG_W-1:0]  cfg_data      = '0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [FILE_W-1:0] in_file_id    = '0;
  logic [PAGE_W-1:0] in_page_index = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic              out_access_kind;
  logic [FRAME_W-1:0] out_frame;
  logic              out_evicted;
  logic [FILE_W-1:0] out_evicted_file;
  logic [PAGE_W-1:0] out_evicted_page;
  logic              out_write_back;

  demand_paging_lru_frame_manager #(
    .FRAMES    (NFRAMES),
    .FILES     (4),
    .PAGE_BITS (PAGE_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_file_id       (in_file_id),
    .in_page_index    (in_page_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_access_kind  (out_access_kind),
    .out_frame        (out_frame),
    .out_evicted      (out_evicted),
    .out_evicted_file (out_evicted_file),
    .out_evicted_page (out_evicted_page),
    .out_write_back   (out_write_back)
  );

  always #4 clk = ~clk;

  // Predicted frame table; ages are recency ranks, 0 = most recent
  bit                tbl_valid [NFRAMES];
  bit                tbl_dirty [NFRAMES];
  logic [FILE_W-1:0] tbl_file  [NFRAMES];
  logic [PAGE_W-1:0] tbl_page  [NFRAMES];
  int                tbl_age   [NFRAMES];
  logic [CFG_W-1:0]  pool_reg = dplru_pkg::CFG_RESET;

  fault_t        fault_backlog[$];
  frame_result_t pending_results[$];
  fault_t        hot_set[$];

  int  errors = 0;
  int  faults_taken = 0;
  int  upgrades = 0;
  int  evictions = 0;
  int  write_backs = 0;
  int  pool_writes = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  idle_cycles = 0;
  bit  fault_xfer = 1'b0;

  // Move frame f to the front; valid frames younger than old_age age by one
  function automatic void promote_frame(int f, int old_age);
    for (int i = 0; i < NFRAMES; i++)
      if (tbl_valid[i] && i != f && tbl_age[i] < old_age) tbl_age[i]++;
    tbl_age[f] = 0;
  endfunction

  function automatic frame_result_t serve_fault(logic [FILE_W-1:0] fid,
                                                logic [PAGE_W-1:0] pg);
    frame_result_t res;
    int pool, slot, live, oldest;
    res  = '0;
    pool = (pool_reg == 0) ? 1 : ((pool_reg > NFRAMES) ? NFRAMES : int'(pool_reg));
    slot = -1;
    live = 0;
    // lookup covers every frame, also those beyond the pool
    for (int i = 0; i < NFRAMES; i++) begin
      if (tbl_valid[i]) begin
        live++;
        if (slot < 0 && tbl_file[i] == fid && tbl_page[i] == pg) slot = i;
      end
    end
    if (slot >= 0) begin
      tbl_dirty[slot] = 1'b1;
      promote_frame(slot, tbl_age[slot]);
      res.kind  = dplru_pkg::KIND_UPGRADE;
      res.frame = slot[FRAME_W-1:0];
      upgrades++;
      return res;
    end
    // lowest free frame inside the pool
    for (int i = 0; i < pool; i++)
      if (slot < 0 && !tbl_valid[i]) slot = i;
    // none free: evict the oldest frame inside the pool
    if (slot < 0) begin
      oldest = -1;
      for (int i = 0; i < pool; i++) begin
        if (tbl_valid[i] && tbl_age[i] > oldest) begin
          oldest = tbl_age[i];
          slot   = i;
        end
      end
      res.evicted    = 1'b1;
      res.ev_file    = tbl_file[slot];
      res.ev_page    = tbl_page[slot];
      res.write_back = tbl_dirty[slot];
      evictions++;
      if (tbl_dirty[slot]) write_backs++;
      tbl_valid[slot] = 1'b0;
      for (int i = 0; i < NFRAMES; i++)
        if (tbl_valid[i] && tbl_age[i] > oldest) tbl_age[i]--;
      live--;
    end
    tbl_valid[slot] = 1'b1;
    tbl_dirty[slot] = 1'b0;
    tbl_file[slot]  = fid;
    tbl_page[slot]  = pg;
    promote_frame(slot, live);
    res.kind  = dplru_pkg::KIND_FILL;
    res.frame = slot[FRAME_W-1:0];
    return res;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Monitor: check results, predict on each accepted fault
  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, frame %0d",
                   $time, out_frame);
        end else begin
          want = pending_results.pop_front();
          report_field("access_kind", 32'(want.kind), 32'(out_access_kind));
          report_field("frame", 32'(want.frame), 32'(out_frame));
          report_field("evicted", 32'(want.evicted), 32'(out_evicted));
          report_field("evicted_file", 32'(want.ev_file), 32'(out_evicted_file));
          report_field("evicted_page", 32'(want.ev_page), 32'(out_evicted_page));
          report_field("write_back", 32'(want.write_back), 32'(out_write_back));
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(serve_fault(in_file_id, in_page_index));
        faults_taken++;
      end
    end
    fault_xfer <= in_valid && in_ready;
  end

  // Watchdog: stop if no transfer of any kind for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Fault driver: bursts of faults with random gaps
  always @(negedge clk) begin : fault_driver
    static int burst_left = 1;
    static int gap_left   = 0;
    fault_t    item;
    logic      v_next;
    v_next = in_valid;
    if (in_valid && fault_xfer) v_next = 1'b0;
    if (rst_n && !v_next) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (fault_backlog.size() > 0) begin
        item          = fault_backlog.pop_front();
        in_file_id    <= item.file_id;
        in_page_index <= item.page;
        v_next        = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
        end
      end
    end
    in_valid <= v_next;
  end

  // Result receiver: own stall pattern plus requested long hold-offs
  always @(negedge clk) begin : result_sink
    static int hold_left = 0;
    static int mode      = RX_OPEN;
    static int mode_left = 0;
    logic      rdy;
    rdy = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(RX_OPEN, RX_SPARSE);
        mode_left = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      case (mode)
        RX_OPEN:   rdy = 1'b1;
        RX_CHOPPY: rdy = ($urandom_range(0, 1) == 1);
        RX_SPARSE: rdy = ($urandom_range(0, 7) == 0);
        default:   rdy = 1'b1;
      endcase
    end
    out_ready <= rdy;
  end

  task automatic queue_fault(input logic [FILE_W-1:0] fid, input logic [PAGE_W-1:0] pg);
    fault_t f;
    f.file_id = fid;
    f.page    = pg;
    fault_backlog.push_back(f);
  endtask

  // Wait until every fault is sent and every result is back
  task automatic settle();
    while (fault_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pool(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    pool_reg = v;
    pool_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Working set for locality: keep about half of the old one
  task automatic refresh_hot_set(input int pool);
    fault_t keep[$];
    fault_t f;
    int     want;
    want = $urandom_range((pool + 1) / 2, pool + pool / 2 + 2);
    foreach (hot_set[i])
      if ($urandom_range(0, 1)) keep.push_back(hot_set[i]);
    while (keep.size() > want) keep.delete(keep.size() - 1);
    while (keep.size() < want) begin
      f.file_id = FILE_W'($urandom_range(0, 3));
      f.page    = PAGE_W'($urandom_range(0, 20'hFFFFF));
      keep.push_back(f);
    end
    hot_set = keep;
  endtask

  function automatic fault_t draw_fault();
    fault_t f;
    int     roll;
    roll = $urandom_range(0, 99);
    f    = hot_set[$urandom_range(0, hot_set.size() - 1)];
    if (roll >= 95) begin
      f.file_id = FILE_W'($urandom_range(0, 3));
      f.page    = $urandom_range(0, 1) ? '1 : '0;
    end else if (roll >= 85) begin
      f.file_id = FILE_W'($urandom_range(0, 3));
      f.page    = PAGE_W'($urandom_range(0, 20'hFFFFF));
    end else if (roll >= 75) begin
      // near miss: one bit off a working-set tag
      if ($urandom_range(0, 3) == 0)
        f.file_id = f.file_id ^ (2'b01 << $urandom_range(0, FILE_W - 1));
      else
        f.page = f.page ^ (20'h00001 << $urandom_range(0, PAGE_W - 1));
    end
    return f;
  endfunction

  initial begin : stimulus
    int v, eff;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fills, upgrade, upgrade of a dirty page, same page other file
    queue_fault(2'd0, 20'h00000);
    queue_fault(2'd3, 20'hFFFFF);
    queue_fault(2'd0, 20'h00000);
    queue_fault(2'd0, 20'h00000);
    queue_fault(2'd1, 20'hAAAAA);
    queue_fault(2'd2, 20'h55555);
    queue_fault(2'd3, 20'h00000);
    queue_fault(2'd0, 20'h00001);
    settle();

    // Pool shrunk below resident frames: hit above the pool, victims inside it
    set_pool(7'd2);
    queue_fault(2'd2, 20'h55555);
    queue_fault(2'd1, 20'h12345);
    queue_fault(2'd1, 20'h12345);
    queue_fault(2'd0, 20'h54321);
    queue_fault(2'd2, 20'hFFFFE);
    settle();

    // Zero acts as a one-frame pool; evict a dirty frame for a write-back
    set_pool(7'd0);
    queue_fault(2'd3, 20'hF0F0F);
    queue_fault(2'd3, 20'hF0F0F);
    queue_fault(2'd2, 20'h0F0F0);
    queue_fault(2'd1, 20'h00000);
    settle();

    // Oversized value acts as the full table
    set_pool(7'd127);
    queue_fault(2'd1, 20'hFFFFF);
    queue_fault(2'd2, 20'hFFFFF);
    queue_fault(2'd0, 20'h80000);
    settle();

    // Random phases over a spread of pool sizes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       v = 64;
        1:       v = 1;
        2:       v = 8;
        3:       v = 127;
        4:       v = 0;
        5:       v = 2;
        6:       v = 64;
        7:       v = 65;
        default: v = $urandom_range(0, 127);
      endcase
      set_pool(v[CFG_W-1:0]);
      eff = (v == 0) ? 1 : ((v > NFRAMES) ? NFRAMES : v);
      refresh_hot_set(eff);
      if (ph == 2 || ph == 9) hold_requests++;
      for (int k = 0; k < FAULTS_PER_PHASE; k++)
        fault_backlog.push_back(draw_fault());
      settle();
    end

    repeat (2 * FAULT_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Covered %0d faults: %0d upgrades, %0d evictions, %0d with write-back.",
             faults_taken, upgrades, evictions, write_backs);
    $display("Pool size written %0d times (0 to 127), %0d long output hold-offs.",
             pool_writes, holds_served);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
